### design/ucc_pkg.sv
// ----------------------------------------------------------------------------
// ucc_pkg
// Shared types, constants and the display width range table for the UTF-8
// terminal column counter.
// ----------------------------------------------------------------------------
package ucc_pkg;

  // Width of the internal saturating column total.
  localparam int COUNT_BITS = 16;
  // Width of the column_count result field.
  localparam int COUNT_FIELD_W = 16;
  // Bits held for a code point under assembly.
  localparam int CP_BITS = 21;
  localparam int NUM_RANGES = 22;

  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [CP_BITS-1:0]       code_point_t;
  typedef logic [1:0]               cols_t;
  typedef logic [1:0]               pending_t;

  localparam count_t COUNT_MAX = '1;

  localparam logic [7:0] ESC_BYTE     = 8'h1B;
  localparam logic [7:0] ESC_END_BYTE = 8'h6D;  // 'm'

  // Byte class masks and patterns.
  localparam logic [7:0] TOP_BIT_MASK = 8'h80;
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_PAT     = 8'h80;
  localparam logic [7:0] LEAD2_MASK   = 8'hE0;
  localparam logic [7:0] LEAD2_PAT    = 8'hC0;
  localparam logic [7:0] LEAD3_MASK   = 8'hF0;
  localparam logic [7:0] LEAD3_PAT    = 8'hE0;
  localparam logic [7:0] LEAD4_MASK   = 8'hF8;
  localparam logic [7:0] LEAD4_PAT    = 8'hF0;

  localparam cols_t COLS_DEFAULT = 2'd1;

  typedef struct packed {
    code_point_t lo;
    code_point_t hi;
    cols_t       cols;
  } width_range_t;

  // Checked in order: the first range that matches decides.
  localparam width_range_t WIDTH_TABLE [NUM_RANGES] = '{
    '{21'h02500, 21'h0259F, 2'd1}, '{21'h02600, 21'h026FF, 2'd1},
    '{21'h02700, 21'h027BF, 2'd1}, '{21'h01100, 21'h0115F, 2'd2},
    '{21'h02E80, 21'h0303E, 2'd2}, '{21'h03041, 21'h033FF, 2'd2},
    '{21'h03400, 21'h04DBF, 2'd2}, '{21'h04E00, 21'h09FFF, 2'd2},
    '{21'h0A000, 21'h0A4CF, 2'd2}, '{21'h0AC00, 21'h0D7A3, 2'd2},
    '{21'h0F900, 21'h0FAFF, 2'd2}, '{21'h0FE30, 21'h0FE4F, 2'd2},
    '{21'h0FF00, 21'h0FF60, 2'd2}, '{21'h0FFE0, 21'h0FFE6, 2'd2},
    '{21'h1F300, 21'h1F64F, 2'd2}, '{21'h1F680, 21'h1F6FF, 2'd2},
    '{21'h1F700, 21'h1F77F, 2'd2}, '{21'h1F900, 21'h1F9FF, 2'd2},
    '{21'h1FA70, 21'h1FAFF, 2'd2}, '{21'h0FE0F, 21'h0FE0F, 2'd0},
    '{21'h0200D, 21'h0200D, 2'd0}, '{21'h00300, 21'h0036F, 2'd0}
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_end;
  } ucc_item_t;

  typedef struct packed {
    count_t total;
    logic   is_final;
  } ucc_result_t;

endpackage

### design/ucc_width.sv
// ----------------------------------------------------------------------------
// ucc_width
// Scores one code point as 0, 1 or 2 terminal columns from the range table.
// ----------------------------------------------------------------------------
module ucc_width
  import ucc_pkg::*;
(
  input  code_point_t cp,
  output cols_t       cols
);

  // All ranges are compared in parallel; walking the table from the end lets
  // the earliest matching entry win.
  always_comb begin
    cols = COLS_DEFAULT;
    for (int i = NUM_RANGES - 1; i >= 0; i--) begin
      if (cp >= WIDTH_TABLE[i].lo && cp <= WIDTH_TABLE[i].hi) begin
        cols = WIDTH_TABLE[i].cols;
      end
    end
  end

endmodule

### design/ucc_core.sv
// ----------------------------------------------------------------------------
// ucc_core
// Decoder state and single-pass update: escape tracking, UTF-8 assembly,
// width scoring and the saturating column total.
// ----------------------------------------------------------------------------
module ucc_core
  import ucc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  ucc_item_t   item,
  output ucc_result_t result
);

  logic        in_escape, in_escape_next;
  pending_t    bytes_pending, bytes_pending_next;
  code_point_t partial_code_point, partial_code_point_next;
  count_t      column_total;

  logic [7:0]  b;
  logic        last;
  logic        have_pend;
  logic        cont;
  logic        taken;
  pending_t    pend_dec;
  code_point_t cp_shift;
  code_point_t lookup_cp;
  cols_t       w;
  logic        score_w;
  logic        byte_add;
  logic        new_lead;
  logic [1:0]  add;
  logic [COUNT_BITS:0] sum;
  count_t      sat_total;

  assign b         = item.text_byte;
  assign last      = item.string_end;
  assign have_pend = (bytes_pending != '0);
  assign cont      = ((b & CONT_MASK) == CONT_PAT);
  assign taken     = have_pend && cont;
  assign pend_dec  = bytes_pending - pending_t'(1);
  assign cp_shift  = {partial_code_point[CP_BITS-7:0], b[5:0]};
  // Only one code point is ever scored by the table per byte: either the one
  // being extended, or a truncated one cut short by this byte.
  assign lookup_cp = taken ? cp_shift : partial_code_point;

  ucc_width u_width (
    .cp   (lookup_cp),
    .cols (w)
  );

  always_comb begin
    in_escape_next          = in_escape;
    bytes_pending_next      = taken ? pend_dec : '0;
    partial_code_point_next = taken ? cp_shift : partial_code_point;
    byte_add                = 1'b0;
    new_lead                = 1'b0;
    if (!taken) begin
      if (b == ESC_BYTE) begin
        in_escape_next = 1'b1;
      end else if (in_escape) begin
        if (b == ESC_END_BYTE) begin
          in_escape_next = 1'b0;
        end
      end else if ((b & TOP_BIT_MASK) == '0) begin
        byte_add = 1'b1;
      end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
        partial_code_point_next = CP_BITS'(b[4:0]);
        bytes_pending_next      = pending_t'(1);
        new_lead                = 1'b1;
      end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
        partial_code_point_next = CP_BITS'(b[3:0]);
        bytes_pending_next      = pending_t'(2);
        new_lead                = 1'b1;
      end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
        partial_code_point_next = CP_BITS'(b[2:0]);
        bytes_pending_next      = pending_t'(3);
        new_lead                = 1'b1;
      end else begin
        byte_add = 1'b1;
      end
    end
  end

  // A code point that completes, or is cut short by a byte that is not a
  // continuation or by the string end, is scored by the table. A fresh lead byte
  // flushed at the string end holds at most five bits, which always scores one column.
  assign score_w = taken ? ((pend_dec == '0) || last) : have_pend;
  assign add     = (score_w ? w : 2'd0) + {1'b0, byte_add}
                 + {1'b0, last && new_lead};
  assign sum       = {1'b0, column_total} + (COUNT_BITS + 1)'(add);
  assign sat_total = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];

  assign result.total    = sat_total;
  assign result.is_final = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape          <= 1'b0;
      bytes_pending      <= '0;
      partial_code_point <= '0;
      column_total       <= '0;
    end else if (step) begin
      if (last) begin
        in_escape          <= 1'b0;
        bytes_pending      <= '0;
        partial_code_point <= '0;
        column_total       <= '0;
      end else begin
        in_escape          <= in_escape_next;
        bytes_pending      <= bytes_pending_next;
        partial_code_point <= partial_code_point_next;
        column_total       <= sat_total;
      end
    end
  end

  // A code point is never under assembly inside an escape run.
  assert property (@(posedge clk) disable iff (rst)
    !(in_escape && (bytes_pending != '0)))
    else $error("escape run and pending code point at the same time");

  // The string end leaves the decoder in its reset state.
  assert property (@(posedge clk) disable iff (rst)
    (step && item.string_end) |=>
      (column_total == '0) && (bytes_pending == '0) && !in_escape)
    else $error("state not cleared after string end");

  // Within a string the total never goes down.
  assert property (@(posedge clk) disable iff (rst)
    (step && !item.string_end) |=> (column_total >= $past(column_total)))
    else $error("column total decreased within a string");

endmodule

### design/utf8_terminal_column_counter.sv
// A byte is first held in the input register; its total is then written to the
// result register, and either register can hold while out_ready is low.
// Throughput: one byte per cycle while out_ready is high; decoder update and
// width lookup settle in the single stage between the input and result registers.
// in_ready drops only while both registers are full and out_ready is low.
// Reset (rst, synchronous) empties both registers and clears the decoder state.
// ----------------------------------------------------------------------------
// utf8_terminal_column_counter
// Counts the terminal columns taken by a UTF-8 byte stream with embedded
// escape runs, giving one running total for each byte.
// ----------------------------------------------------------------------------
module utf8_terminal_column_counter
  import ucc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               text_byte,
  input  logic                     string_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COUNT_FIELD_W-1:0] column_count,
  output logic                     count_final
);

  // The input register holds one transaction ahead of the decoder; the result
  // register holds the total for the byte most recently decoded.
  logic        s1_valid;
  ucc_item_t   s1_item;
  logic        advance;
  logic        step;
  ucc_result_t result;

  // The pipeline moves whenever the result register is empty or being read.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  // The decoder state changes only when its result is written, so the state
  // matches the last total shown on the output, but after a string end it is back in reset.
  ucc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.text_byte  <= text_byte;
      s1_item.string_end <= string_end;
    end
    if (step) begin
      column_count <= COUNT_FIELD_W'(result.total);
      count_final  <= result.is_final;
    end
  end

endmodule
